// ----- rtl/dagjls_pkg.sv -----
// Shared constants, datapath operation codes and controller states
// for the job level scheduler. No dependencies.
`default_nettype none
package dagjls_pkg;
   localparam int MAX_VERTICES = 64;
   localparam int MAX_EDGES    = 256;
   localparam int VX_W   = 6;                         // job number width
   localparam int CNT_W  = 7;                         // job count, time width
   localparam int ETOT_W = $clog2(MAX_EDGES + 1);     // edge count width
   localparam int EADR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int PEND_W = $clog2(MAX_EDGES + 1);     // predecessor count width
   localparam int EDGE_W = 2 * VX_W;
   localparam logic [CNT_W-1:0] VC_RESET = CNT_W'(MAX_VERTICES);
   localparam logic [CNT_W-1:0] TIME_MAX = {CNT_W{1'b1}};
   localparam logic [2:0]       ADDR_VERTEX_COUNT = 3'd0;

   typedef enum logic [3:0] {
      OP_NONE, OP_ADD, OP_START, OP_CLEAR, OP_CNT_EDGE, OP_CNT_PEND, OP_CNT_WRITE,
      OP_IDX_RST, OP_SEED_RD, OP_SEED_WR, OP_POP, OP_NODE_TIME, OP_SCAN_EDGE,
      OP_SCAN_PEND, OP_SCAN_WRITE, OP_EMIT_LOAD
   } dp_op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CLEAR, S_CNT_EDGE, S_CNT_PEND, S_CNT_WRITE, S_SEED_RD, S_SEED_WR,
      S_POP, S_NODE_TIME, S_SCAN_EDGE, S_SCAN_PEND, S_SCAN_WRITE, S_EMIT_LOAD,
      S_EMIT_WAIT, S_FINISH
   } state_type;

   typedef struct packed {
      dp_op_type op;
      logic      finish;     // empty the edge store, clear the drop flag
   } cmd_type;

   typedef struct packed {
      logic idx_end;
      logic edge_end;
      logic queue_empty;
      logic rsp_taken;
   } status_type;
endpackage
`default_nettype wire

// ----- rtl/dagjls_ctrl.sv -----
// Controller state machine for the job level scheduler.
// Depends on dagjls_pkg; drives dagjls_dp through cmd_type.
`default_nettype none
module dagjls_ctrl
   import dagjls_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_command,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      cmd.finish = 1'b0;
      req_ready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command) begin
                  cmd.op   = OP_START;
                  state_in = S_CLEAR;
               end else begin
                  cmd.op = OP_ADD;
               end
            end
         end
         S_CLEAR: begin
            if (status.idx_end) begin
               state_in = S_CNT_EDGE;
            end else begin
               cmd.op = OP_CLEAR;
            end
         end
         S_CNT_EDGE: begin
            if (status.edge_end) begin
               cmd.op   = OP_IDX_RST;
               state_in = S_SEED_RD;
            end else begin
               cmd.op   = OP_CNT_EDGE;
               state_in = S_CNT_PEND;
            end
         end
         S_CNT_PEND: begin
            cmd.op   = OP_CNT_PEND;
            state_in = S_CNT_WRITE;
         end
         S_CNT_WRITE: begin
            cmd.op   = OP_CNT_WRITE;
            state_in = S_CNT_EDGE;
         end
         S_SEED_RD: begin
            if (status.idx_end) begin
               state_in = S_POP;
            end else begin
               cmd.op   = OP_SEED_RD;
               state_in = S_SEED_WR;
            end
         end
         S_SEED_WR: begin
            cmd.op   = OP_SEED_WR;
            state_in = S_SEED_RD;
         end
         S_POP: begin
            if (status.queue_empty) begin
               cmd.op   = OP_IDX_RST;
               state_in = S_EMIT_LOAD;
            end else begin
               cmd.op   = OP_POP;
               state_in = S_NODE_TIME;
            end
         end
         S_NODE_TIME: begin
            cmd.op   = OP_NODE_TIME;
            state_in = S_SCAN_EDGE;
         end
         S_SCAN_EDGE: begin
            if (status.edge_end) begin
               state_in = S_POP;
            end else begin
               cmd.op   = OP_SCAN_EDGE;
               state_in = S_SCAN_PEND;
            end
         end
         S_SCAN_PEND: begin
            cmd.op   = OP_SCAN_PEND;
            state_in = S_SCAN_WRITE;
         end
         S_SCAN_WRITE: begin
            cmd.op   = OP_SCAN_WRITE;
            state_in = S_SCAN_EDGE;
         end
         S_EMIT_LOAD: begin
            cmd.op   = OP_EMIT_LOAD;
            state_in = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (status.rsp_taken) begin
               state_in = status.idx_end ? S_FINISH : S_EMIT_LOAD;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ----- rtl/dagjls_dp.sv -----
// Datapath for the job level scheduler: edge store, predecessor counts,
// job times, ready queue, counters and result register. Depends on dagjls_pkg.
`default_nettype none
module dagjls_dp
   import dagjls_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   output status_type            status,
   input  wire logic [CNT_W-1:0] count,
   input  wire logic [VX_W-1:0]  req_edge_source,
   input  wire logic [VX_W-1:0]  req_edge_target,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [VX_W-1:0]       rsp_job_index,
   output logic [CNT_W-1:0]      rsp_finish_time,
   output logic                  rsp_last,
   output logic                  rsp_edge_dropped
);
   logic [EDGE_W-1:0] edge_mem  [MAX_EDGES];
   logic [PEND_W-1:0] pend_mem  [MAX_VERTICES];
   logic [CNT_W-1:0]  time_mem  [MAX_VERTICES];
   logic [VX_W-1:0]   queue_mem [MAX_VERTICES];

   logic [ETOT_W-1:0] edge_total_ff, e_ff;
   logic              drop_ff;
   logic [CNT_W-1:0]  i_ff, head_ff, tail_ff;
   logic [EDGE_W-1:0] edge_q_ff;
   logic [PEND_W-1:0] pend_q_ff;
   logic [CNT_W-1:0]  time_q_ff;
   logic [VX_W-1:0]   node_ff;
   logic              rsp_valid_ff, rsp_last_ff, rsp_drop_ff;
   logic [VX_W-1:0]   rsp_index_ff;
   logic [CNT_W-1:0]  rsp_time_ff;

   logic [VX_W-1:0] es, et;
   logic            in_range, match, add_ok, pend_zero, pend_one, q_room;
   logic [CNT_W-1:0] next_time;

   assign es        = edge_q_ff[EDGE_W-1:VX_W];
   assign et        = edge_q_ff[VX_W-1:0];
   assign in_range  = ({1'b0, es} < count) && ({1'b0, et} < count);
   assign match     = (es == node_ff) && ({1'b0, et} < count);
   assign pend_zero = (pend_q_ff == '0);
   assign pend_one  = (pend_q_ff == PEND_W'(1));
   assign q_room    = (tail_ff < CNT_W'(MAX_VERTICES));
   assign next_time = (time_q_ff == TIME_MAX) ? TIME_MAX : time_q_ff + CNT_W'(1);
   assign add_ok    = (edge_total_ff < ETOT_W'(MAX_EDGES)) &&
                      ({1'b0, req_edge_source} < count) &&
                      ({1'b0, req_edge_target} < count);

   assign status.idx_end     = (i_ff == count);
   assign status.edge_end    = (e_ff == edge_total_ff);
   assign status.queue_empty = (head_ff == tail_ff);
   assign status.rsp_taken   = rsp_valid_ff && rsp_ready;

   // edge store
   always_ff @(posedge clock) begin
      if (cmd.op == OP_ADD && add_ok) begin
         edge_mem[edge_total_ff[EADR_W-1:0]] <= {req_edge_source, req_edge_target};
      end
      if (cmd.op == OP_CNT_EDGE || cmd.op == OP_SCAN_EDGE) begin
         edge_q_ff <= edge_mem[e_ff[EADR_W-1:0]];
      end
   end

   // predecessor counts
   logic              pend_we;
   logic [VX_W-1:0]   pend_wa;
   logic [PEND_W-1:0] pend_wd;
   always_comb begin
      pend_we = 1'b0;
      pend_wa = et;
      pend_wd = pend_q_ff + PEND_W'(1);
      unique case (cmd.op)
         OP_CLEAR: begin
            pend_we = 1'b1;
            pend_wa = i_ff[VX_W-1:0];
            pend_wd = '0;
         end
         OP_CNT_WRITE:  pend_we = in_range;
         OP_SCAN_WRITE: begin
            pend_we = match && !pend_zero;
            pend_wd = pend_q_ff - PEND_W'(1);
         end
         default: pend_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_wa] <= pend_wd;
      end
      if (cmd.op == OP_CNT_PEND || cmd.op == OP_SCAN_PEND) begin
         pend_q_ff <= pend_mem[et];
      end else if (cmd.op == OP_SEED_RD) begin
         pend_q_ff <= pend_mem[i_ff[VX_W-1:0]];
      end
   end

   // job times and ready queue
   logic             time_we, queue_we;
   logic [VX_W-1:0]  time_wa;
   logic [CNT_W-1:0] time_wd;
   logic [VX_W-1:0]  queue_wd;
   always_comb begin
      time_we  = 1'b0;
      time_wa  = et;
      time_wd  = next_time;
      queue_we = 1'b0;
      queue_wd = et;
      unique case (cmd.op)
         OP_CLEAR: begin
            time_we = 1'b1;
            time_wa = i_ff[VX_W-1:0];
            time_wd = '0;
         end
         OP_SEED_WR: begin
            time_we  = pend_zero;
            time_wa  = i_ff[VX_W-1:0];
            time_wd  = CNT_W'(1);
            queue_we = pend_zero;
            queue_wd = i_ff[VX_W-1:0];
         end
         OP_SCAN_WRITE: begin
            time_we  = match && pend_one;
            queue_we = match && pend_one && q_room;
         end
         default: time_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (time_we) begin
         time_mem[time_wa] <= time_wd;
      end
      if (cmd.op == OP_NODE_TIME) begin
         time_q_ff <= time_mem[node_ff];
      end
      if (cmd.op == OP_EMIT_LOAD) begin
         rsp_time_ff  <= time_mem[i_ff[VX_W-1:0]];
         rsp_index_ff <= i_ff[VX_W-1:0];
         rsp_last_ff  <= (i_ff + CNT_W'(1) == count);
         rsp_drop_ff  <= drop_ff;
      end
      if (queue_we) begin
         queue_mem[tail_ff[VX_W-1:0]] <= queue_wd;
      end
      if (cmd.op == OP_POP) begin
         node_ff <= queue_mem[head_ff[VX_W-1:0]];
      end
   end

   // counters and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_total_ff <= '0;
         drop_ff       <= 1'b0;
         e_ff          <= '0;
         i_ff          <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.finish) begin
            edge_total_ff <= '0;
            drop_ff       <= 1'b0;
         end
         if (status.rsp_taken) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd.op)
            OP_ADD: begin
               if (add_ok) begin
                  edge_total_ff <= edge_total_ff + ETOT_W'(1);
               end else begin
                  drop_ff <= 1'b1;
               end
            end
            OP_START: begin
               e_ff    <= '0;
               i_ff    <= '0;
               head_ff <= '0;
               tail_ff <= '0;
            end
            OP_CLEAR, OP_SEED_WR: begin
               i_ff <= i_ff + CNT_W'(1);
               if (cmd.op == OP_SEED_WR && pend_zero) begin
                  tail_ff <= tail_ff + CNT_W'(1);
               end
            end
            OP_CNT_WRITE: e_ff <= e_ff + ETOT_W'(1);
            OP_SCAN_WRITE: begin
               e_ff <= e_ff + ETOT_W'(1);
               if (match && pend_one && q_room) begin
                  tail_ff <= tail_ff + CNT_W'(1);
               end
            end
            OP_IDX_RST:   i_ff <= '0;
            OP_POP:       head_ff <= head_ff + CNT_W'(1);
            OP_NODE_TIME: e_ff <= '0;
            OP_EMIT_LOAD: begin
               i_ff         <= i_ff + CNT_W'(1);
               rsp_valid_ff <= 1'b1;
            end
            default: e_ff <= e_ff;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_job_index    = rsp_index_ff;
   assign rsp_finish_time  = rsp_time_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_edge_dropped = rsp_drop_ff;
endmodule
`default_nettype wire

// ----- rtl/dag_job_level_scheduler.sv -----
// Job level scheduler top: register port, job count clamp, controller and datapath.
// Depends on dagjls_pkg, dagjls_ctrl and dagjls_dp.
//
// Usage: set vertex_count over the register port (byte address 0), then send
// edges on req_ (command 0), one transfer per cycle while idle. Edges that name
// a job at or above the count, or that exceed the edge store, are dropped and
// flagged in rsp_edge_dropped. A command 1 transfer starts a run: the block
// clears its tables, counts predecessors over every edge, seeds the ready
// queue with the jobs that have none, then for each dequeued job scans every
// edge. Results follow in job order; each result is held until it is taken
// before the next one is loaded, and rsp_last marks the final job. A stalled
// receiver holds the result register and the run.
// req_ready is low for the whole run. After the last transfer the edge store
// empties and the drop flag clears. Reset empties the store, clears the flag
// and sets the job count to 64; no clearing pass is needed.
`default_nettype none
module dag_job_level_scheduler
   import dagjls_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_command,
   input  wire logic [VX_W-1:0]   req_edge_source,
   input  wire logic [VX_W-1:0]   req_edge_target,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [VX_W-1:0]        rsp_job_index,
   output logic [CNT_W-1:0]       rsp_finish_time,
   output logic                   rsp_last,
   output logic                   rsp_edge_dropped,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   logic [CNT_W-1:0] vc_ff;
   logic [CNT_W-1:0] count;
   logic             hit;
   cmd_type          cmd;
   status_type       status;

   assign csr_pready = 1'b1;
   assign hit        = (csr_paddr == ADDR_VERTEX_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= VC_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit) begin
         vc_ff <= csr_pwdata[CNT_W-1:0];
      end
   end

   assign csr_prdata = hit ? {{(32 - CNT_W){1'b0}}, vc_ff} : 32'd0;

   // zero acts as one job, anything above capacity as full capacity
   always_comb begin
      if (vc_ff == '0) begin
         count = CNT_W'(1);
      end else if (vc_ff > CNT_W'(MAX_VERTICES)) begin
         count = CNT_W'(MAX_VERTICES);
      end else begin
         count = vc_ff;
      end
   end

   dagjls_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .status      (status),
      .cmd         (cmd)
   );

   dagjls_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .count            (count),
      .req_edge_source  (req_edge_source),
      .req_edge_target  (req_edge_target),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_job_index    (rsp_job_index),
      .rsp_finish_time  (rsp_finish_time),
      .rsp_last         (rsp_last),
      .rsp_edge_dropped (rsp_edge_dropped)
   );
endmodule
`default_nettype wire

// ----- rtl/dagjls_checker.sv -----
// Port-level checks for the job level scheduler, bound to the top level.
// Depends on dagjls_pkg and dag_job_level_scheduler.
`default_nettype none
module dagjls_checker
   import dagjls_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_ready,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire logic            rsp_last,
   input wire logic [VX_W-1:0] rsp_job_index
);
   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // no new item while a run is emitting
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input open during result emission");

   // the last transfer ends the run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("result after last");

   // results advance in job order
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> ##1
         (rsp_valid && rsp_job_index == VX_W'($past(rsp_job_index, 2) + VX_W'(1))))
      else $error("job order broken");
endmodule

bind dag_job_level_scheduler dagjls_checker u_dagjls_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_last      (rsp_last),
   .rsp_job_index (rsp_job_index)
);
`default_nettype wire

// ----- verif/dag_job_level_scheduler_test.sv -----
// Self-checking testbench for dag_job_level_scheduler: loads dependency edges,
// runs the level computation and checks every job's finish time.
// Depends on dagjls_pkg and the dag_job_level_scheduler RTL.
`timescale 1ns / 1ps
module dag_job_level_scheduler_test;
   import dagjls_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int SETTLE_CYCLES  = 40;

   typedef struct {
      logic             command;
      logic [VX_W-1:0]  source;
      logic [VX_W-1:0]  target;
   } edge_cmd_type;

   typedef struct {
      logic [VX_W-1:0]  job;
      logic [CNT_W-1:0] finish;
      logic             last;
      logic             dropped;
   } job_time_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_command;
   logic [VX_W-1:0]   req_edge_source;
   logic [VX_W-1:0]   req_edge_target;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [VX_W-1:0]   rsp_job_index;
   logic [CNT_W-1:0]  rsp_finish_time;
   logic              rsp_last;
   logic              rsp_edge_dropped;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [2:0]        csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   edge_cmd_type  pending_cmds[$];
   job_time_type  expected_times[$];
   int            error_count;
   bit            idling_on;
   int            send_gap;
   int            recv_gap;
   int            quiet_cycles;

   // scheduler state mirror
   logic [EDGE_W-1:0] edge_mem[$];
   logic              drop_seen;
   logic [CNT_W-1:0]  job_count_reg;

   dag_job_level_scheduler u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_edge_source(req_edge_source), .req_edge_target(req_edge_target),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_job_index(rsp_job_index),
      .rsp_finish_time(rsp_finish_time), .rsp_last(rsp_last),
      .rsp_edge_dropped(rsp_edge_dropped),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int active_jobs();
      int c;
      c = job_count_reg;
      if (c < 1) c = 1;
      if (c > MAX_VERTICES) c = MAX_VERTICES;
      return c;
   endfunction

   function automatic void store_edge(logic [VX_W-1:0] s, logic [VX_W-1:0] t);
      int c;
      c = active_jobs();
      if (edge_mem.size() >= MAX_EDGES || s >= c || t >= c) drop_seen = 1'b1;
      else edge_mem.insert(edge_mem.size(), {s, t});
   endfunction

   // Kahn pass over the stored edges, then queue one finish time per job
   function automatic void predict_levels();
      int c, head, tail, node, s, t, tm;
      int pend[MAX_VERTICES];
      int times[MAX_VERTICES];
      int order[MAX_VERTICES];
      job_time_type r;
      c = active_jobs();
      for (int i = 0; i < MAX_VERTICES; i++) begin
         pend[i] = 0;
         times[i] = 0;
      end
      foreach (edge_mem[e]) begin
         s = edge_mem[e][EDGE_W-1:VX_W];
         t = edge_mem[e][VX_W-1:0];
         if (s < c && t < c) pend[t]++;
      end
      tail = 0;
      for (int i = 0; i < c; i++) begin
         if (pend[i] == 0) begin
            times[i] = 1;
            order[tail] = i;
            tail++;
         end
      end
      head = 0;
      while (head < tail) begin
         node = order[head];
         head++;
         foreach (edge_mem[e]) begin
            s = edge_mem[e][EDGE_W-1:VX_W];
            t = edge_mem[e][VX_W-1:0];
            if (s == node && t < c && pend[t] != 0) begin
               pend[t]--;
               if (pend[t] == 0) begin
                  tm = times[node] + 1;
                  times[t] = (tm > 127) ? 127 : tm;
                  if (tail < MAX_VERTICES) begin
                     order[tail] = t;
                     tail++;
                  end
               end
            end
         end
      end
      for (int i = 0; i < c; i++) begin
         r.job = i[VX_W-1:0];
         r.finish = times[i][CNT_W-1:0];
         r.last = (i + 1 == c);
         r.dropped = drop_seen;
         expected_times.insert(expected_times.size(), r);
      end
      edge_mem.delete();
      drop_seen = 1'b0;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!(req_valid && !req_ready)) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() == 0) begin
            req_valid <= 1'b0;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 18);
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_command <= pending_cmds[0].command;
            req_edge_source <= pending_cmds[0].source;
            req_edge_target <= pending_cmds[0].target;
            void'(pending_cmds.pop_front());
         end
      end
   end

   // monitor, receiver stalls and watchdog
   always @(posedge clock) begin
      job_time_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap <= 0;
         quiet_cycles <= 0;
      end else begin
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            recv_gap <= $urandom_range(0, 18);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end

         if (req_valid && req_ready) begin
            if (req_command) predict_levels();
            else store_edge(req_edge_source, req_edge_target);
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_times.size() == 0) begin
               $error("unexpected result transfer: job %0d", rsp_job_index);
               error_count++;
            end else begin
               want = expected_times.pop_front();
               if (rsp_job_index !== want.job) begin
                  $error("job_index: expected %0d, got %0d", want.job, rsp_job_index);
                  error_count++;
               end
               if (rsp_finish_time !== want.finish) begin
                  $error("finish_time: expected %0d, got %0d", want.finish, rsp_finish_time);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  error_count++;
               end
               if (rsp_edge_dropped !== want.dropped) begin
                  $error("edge_dropped: expected %0d, got %0d", want.dropped,
                         rsp_edge_dropped);
                  error_count++;
               end
            end
         end

         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("dag_job_level_scheduler verification failed");
            $finish;
         end else quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_edge(int s, int t);
      edge_cmd_type it;
      it.command = 1'b0;
      it.source = s[VX_W-1:0];
      it.target = t[VX_W-1:0];
      pending_cmds.insert(pending_cmds.size(), it);
   endtask

   task automatic start_run(int s, int t);
      edge_cmd_type it;
      it.command = 1'b1;
      it.source = s[VX_W-1:0];
      it.target = t[VX_W-1:0];
      pending_cmds.insert(pending_cmds.size(), it);
   endtask

   // hold until every transfer is done and the block has settled
   task automatic drain();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_valid || expected_times.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_job_count(int value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_VERTEX_COUNT;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      job_count_reg = value[CNT_W-1:0];
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin
      int sent, n_edges, s, t, c, phase;
      req_command = 1'b0;
      req_edge_source = '0;
      req_edge_target = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      error_count = 0;
      idling_on = 1'b1;
      drop_seen = 1'b0;
      job_count_reg = VC_RESET;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // chain, duplicate, self loop, a cycle feeding a job; run fields ignored
      add_edge(0, 1);
      add_edge(1, 2);
      add_edge(2, 63);
      add_edge(0, 2);
      add_edge(0, 2);
      add_edge(5, 5);
      add_edge(6, 7);
      add_edge(7, 6);
      add_edge(7, 8);
      start_run(63, 63);
      drain();
      // zero count acts as one; out-of-range edge dropped
      write_job_count(0);
      add_edge(0, 0);
      add_edge(1, 0);
      start_run(0, 0);
      drain();
      // count above the maximum clamps
      write_job_count(127);
      add_edge(63, 62);
      start_run(0, 0);
      drain();
      // lower the count after loading
      write_job_count(64);
      add_edge(40, 50);
      add_edge(3, 4);
      drain();
      write_job_count(10);
      start_run(0, 0);
      drain();
      write_job_count(1);
      start_run(0, 0);
      drain();

      sent = 0;
      phase = 0;
      while (sent < 420) begin
         idling_on = (sent < 340) && ($urandom_range(0, 3) != 0);
         if (phase == 3) begin
            // overfill the edge store at full size
            write_job_count(64);
            c = 64;
            n_edges = MAX_EDGES + 4;
         end else begin
            case ($urandom_range(0, 9))
               0: c = 0;
               1: c = 127;
               2: c = 64;
               default: c = $urandom_range(1, 16);
            endcase
            if ($urandom_range(0, 2) != 0) write_job_count(c);
            c = active_jobs();
            n_edges = $urandom_range(0, 18);
         end
         for (int k = 0; k < n_edges; k++) begin
            case ($urandom_range(0, 9))
               0: begin
                  s = $urandom_range(0, 63);
                  t = $urandom_range(0, 63);
               end
               1: begin
                  s = $urandom_range(0, c - 1);
                  t = s;
               end
               default: begin
                  s = $urandom_range(0, c - 1);
                  t = $urandom_range(0, c - 1);
                  if (s > t && $urandom_range(0, 4) != 0) begin
                     int tmp;
                     tmp = s;
                     s = t;
                     t = tmp;
                  end
               end
            endcase
            add_edge(s, t);
         end
         sent += n_edges;
         if ($urandom_range(0, 9) != 0) begin
            start_run($urandom_range(0, 63), $urandom_range(0, 63));
            sent++;
         end
         drain();
         phase++;
      end
      idling_on = 1'b0;
      start_run(0, 0);
      drain();

      if (error_count == 0) begin
         $display("dag_job_level_scheduler verification clean");
      end else begin
         $display("dag_job_level_scheduler verification failed");
      end
      $finish;
   end
endmodule
